FILE: rtl/core/ffca_pkg.sv
package ffca_pkg;

   localparam int POOL_UNITS       = 4096;
   localparam int MAX_FREE_EXTENTS = 512;
   localparam int HEADER_BYTES     = 8;
   localparam int MIN_BLOCK_BYTES  = 24;
   localparam int MIN_BYTES_R8     = ((MIN_BLOCK_BYTES + 7) / 8) * 8;
   localparam int MIN_UNITS        = MIN_BYTES_R8 / 8;

   localparam int UNIT_W  = 12;   // block start in units
   localparam int LEN_W   = 13;   // length in units
   localparam int CNT_W   = 10;   // extent count, 0..MAX_FREE_EXTENTS
   localparam int EIDX_W  = 9;    // extent table address
   localparam int NEED_W  = 14;   // rounded request in units

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_IGNORED  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // request kinds
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic [UNIT_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } extent_type;

endpackage

FILE: rtl/core/ffca_req_if.sv
interface ffca_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] req_bytes;
   logic [14:0] block_addr;

   modport source (output valid, action, req_bytes, block_addr, input ready);
   modport sink   (input valid, action, req_bytes, block_addr, output ready);
endinterface

FILE: rtl/core/ffca_rsp_if.sv
interface ffca_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [14:0] user_addr;
   logic [15:0] granted_bytes;

   modport source (output valid, status, user_addr, granted_bytes, input ready);
   modport sink   (input valid, status, user_addr, granted_bytes, output ready);
endinterface

FILE: rtl/core/first_fit_coalescing_allocator_top.sv
// First-fit heap allocator over a pool of 8-byte units.
// req_chan carries one request: allocate req_bytes, or free the block whose
// user offset is block_addr. rsp_chan returns one response per request:
// status, user offset and block length in bytes, header included.
// csr_we/csr_wdata set the pool size in units and rebuild the pool (one
// free extent covering it); write only while no request is in flight.
// The free-extent table sits in a single-port-write, registered-read RAM, and
// every table visit takes an address state and then a data state. A request
// scans entries in order and, when an extent is removed or inserted, shifts
// the entries behind it. Scan and shift together touch each entry about once.
// A free also reads the block-length RAM once.
// Reset (synchronous) sets the pool to 4096 units; the block then writes the
// initial extent in S_INIT before req_chan.ready rises.
// The response sits in an output register; a new request is accepted while
// it waits, and the block only holds at its end if the old response is still
// not taken.
module first_fit_coalescing_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   ffca_req_if.sink                   req_chan,
   ffca_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [ffca_pkg::LEN_W-1:0] csr_wdata
);
   import ffca_pkg::*;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_FRD  = 4'd2;
   localparam logic [3:0] S_FLEN = 4'd3;
   localparam logic [3:0] S_RD   = 4'd4;
   localparam logic [3:0] S_CHK  = 4'd5;
   localparam logic [3:0] S_SHR  = 4'd6;
   localparam logic [3:0] S_SHW  = 4'd7;
   localparam logic [3:0] S_INR  = 4'd8;
   localparam logic [3:0] S_INW  = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   // memories
   extent_type        ext_mem [MAX_FREE_EXTENTS];
   logic [LEN_W-1:0]  blen_mem [POOL_UNITS];

   extent_type        ext_q;
   logic [LEN_W-1:0]  blen_q;
   logic              ext_we;
   logic [EIDX_W-1:0] ext_waddr, ext_raddr;
   extent_type        ext_wdata;
   logic              blen_we;
   logic [UNIT_W-1:0] blen_waddr;
   logic [LEN_W-1:0]  blen_wdata;

   // control and payload registers
   logic [3:0]        state_ff, state_in;
   logic [LEN_W-1:0]  pool_ff, pool_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              act_ff, act_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [14:0]       addr_ff, addr_in;
   logic [UNIT_W-1:0] fs_ff, fs_in;
   logic [LEN_W-1:0]  fl_ff, fl_in;
   extent_type        prev_ff, prev_in;
   logic              has_prev_ff, has_prev_in;
   logic [1:0]        res_st_ff, res_st_in;
   logic [14:0]       res_ua_ff, res_ua_in;
   logic [15:0]       res_gb_ff, res_gb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;
   logic [14:0]       rsp_ua_ff, rsp_ua_in;
   logic [15:0]       rsp_gb_ff, rsp_gb_in;

   // helpers
   logic [15:0]       req_max;
   logic [16:0]       req_sum;
   logic [14:0]       base;
   logic              bad_free;
   logic              scan_end, found_free, decide_free;
   logic              padj, nadj;
   logic [LEN_W:0]    prev_end;
   logic [LEN_W:0]    free_end;
   logic [LEN_W-1:0]  pool_left;

   always_ff @(posedge clock) begin
      if (ext_we) ext_mem[ext_waddr] <= ext_wdata;
      ext_q <= ext_mem[ext_raddr];
   end

   always_ff @(posedge clock) begin
      if (blen_we) blen_mem[blen_waddr] <= blen_wdata;
      blen_q <= blen_mem[fs_ff];
   end

   // request decode
   assign req_max  = (req_chan.req_bytes > 16'(MIN_BYTES_R8)) ? req_chan.req_bytes
                                                              : 16'(MIN_BYTES_R8);
   assign req_sum  = {1'b0, req_max} + 17'(HEADER_BYTES + 7);
   assign base     = req_chan.block_addr - 15'(HEADER_BYTES);
   assign bad_free = (req_chan.block_addr < 15'(HEADER_BYTES)) || (base[2:0] != 3'd0) ||
                     ({1'b0, base[14:3]} >= pool_ff);

   // free placement checks
   assign scan_end    = (state_ff == S_RD) && (idx_ff >= count_ff);
   assign found_free  = (state_ff == S_CHK) && (act_ff == ACT_FREE) &&
                        (ext_q.start > fs_ff);
   assign decide_free = found_free || (scan_end && (act_ff == ACT_FREE));
   assign prev_end    = {1'b0, prev_ff.length} + {2'b0, prev_ff.start};
   assign free_end    = {2'b0, fs_ff} + {1'b0, fl_ff};
   assign padj        = has_prev_ff && (prev_end == {2'b0, fs_ff});
   assign nadj        = found_free && (free_end == {2'b0, ext_q.start});
   assign pool_left   = pool_ff - {1'b0, fs_ff};

   always_comb begin
      state_in    = state_ff;
      pool_in     = pool_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      act_in      = act_ff;
      need_in     = need_ff;
      addr_in     = addr_ff;
      fs_in       = fs_ff;
      fl_in       = fl_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      res_st_in   = res_st_ff;
      res_ua_in   = res_ua_ff;
      res_gb_in   = res_gb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_st_in   = rsp_st_ff;
      rsp_ua_in   = rsp_ua_ff;
      rsp_gb_in   = rsp_gb_ff;
      ext_we      = 1'b0;
      ext_waddr   = idx_ff[EIDX_W-1:0];
      ext_wdata   = ext_q;
      ext_raddr   = idx_ff[EIDX_W-1:0];
      blen_we     = 1'b0;
      blen_waddr  = ext_q.start;
      blen_wdata  = ext_q.length;

      case (state_ff)
         // write the single extent covering the pool
         S_INIT: begin
            ext_we           = 1'b1;
            ext_waddr        = '0;
            ext_wdata.start  = '0;
            ext_wdata.length = pool_ff;
            count_in         = CNT_W'(1);
            state_in         = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in      = req_chan.action;
               need_in     = req_sum[16:3];
               addr_in     = req_chan.block_addr;
               fs_in       = base[14:3];
               idx_in      = '0;
               has_prev_in = 1'b0;
               if (req_chan.action == ACT_ALLOC) begin
                  state_in = S_RD;
               end else if (bad_free) begin
                  res_st_in = ST_IGNORED;
                  res_ua_in = req_chan.block_addr;
                  res_gb_in = '0;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_FRD;
               end
            end
         end
         // block length read issued from fs_ff
         S_FRD: state_in = S_FLEN;
         S_FLEN: begin
            fl_in     = (blen_q > pool_left) ? pool_left : blen_q;
            res_ua_in = addr_ff;
            res_gb_in = {fl_in, 3'b000};
            state_in  = S_RD;
         end
         // scan: issue read of entry idx
         S_RD: begin
            if (scan_end) begin
               if (act_ff == ACT_ALLOC) begin
                  res_st_in = ST_NO_SPACE;
                  res_ua_in = '0;
                  res_gb_in = '0;
                  state_in  = S_RESP;
               end
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (act_ff == ACT_ALLOC) begin
               if ({1'b0, ext_q.length} > need_ff) begin
                  res_st_in  = ST_OK;
                  res_ua_in  = {ext_q.start, 3'b000} + 15'(HEADER_BYTES);
                  blen_we    = 1'b1;
                  blen_waddr = ext_q.start;
                  if ({2'b0, ext_q.length} < ({1'b0, need_ff} + 15'(MIN_UNITS))) begin
                     // grant whole extent, close the gap
                     blen_wdata = ext_q.length;
                     res_gb_in  = {ext_q.length, 3'b000};
                     state_in   = S_SHR;
                  end else begin
                     // split: keep the tail free
                     blen_wdata       = need_ff[LEN_W-1:0];
                     res_gb_in        = {need_ff[LEN_W-1:0], 3'b000};
                     ext_we           = 1'b1;
                     ext_wdata.start  = ext_q.start + need_ff[UNIT_W-1:0];
                     ext_wdata.length = ext_q.length - need_ff[LEN_W-1:0];
                     state_in         = S_RESP;
                  end
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_RD;
               end
            end else if (!found_free) begin
               prev_in     = ext_q;
               has_prev_in = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
               state_in    = S_RD;
            end
         end
         // shift down: entry k <- entry k+1
         S_SHR: begin
            if (idx_ff + CNT_W'(1) < count_ff) begin
               ext_raddr = EIDX_W'(idx_ff + CNT_W'(1));
               state_in  = S_SHW;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESP;
            end
         end
         S_SHW: begin
            ext_we    = 1'b1;
            ext_wdata = ext_q;
            idx_in    = idx_ff + CNT_W'(1);
            state_in  = S_SHR;
         end
         // shift up: entry k <- entry k-1, idx counts from count down
         S_INR: begin
            if (idx_ff > need_ff[CNT_W-1:0]) begin
               ext_raddr = EIDX_W'(idx_ff - CNT_W'(1));
               state_in  = S_INW;
            end else begin
               ext_we           = 1'b1;
               ext_waddr        = idx_ff[EIDX_W-1:0];
               ext_wdata.start  = fs_ff;
               ext_wdata.length = fl_ff;
               count_in         = count_ff + CNT_W'(1);
               state_in         = S_RESP;
            end
         end
         S_INW: begin
            ext_we    = 1'b1;
            ext_wdata = ext_q;
            idx_in    = idx_ff - CNT_W'(1);
            state_in  = S_INR;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_ua_in    = res_ua_ff;
               rsp_gb_in    = res_gb_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase

      // free: merge or insert once position is known, or report a full table
      if (decide_free) begin
         res_st_in = ST_OK;
         if (padj) begin
            ext_we           = 1'b1;
            ext_waddr        = EIDX_W'(idx_ff - CNT_W'(1));
            ext_wdata.start  = prev_ff.start;
            ext_wdata.length = prev_ff.length + fl_ff +
                               (nadj ? ext_q.length : LEN_W'(0));
            state_in         = nadj ? S_SHR : S_RESP;
         end else if (nadj) begin
            ext_we           = 1'b1;
            ext_wdata.start  = fs_ff;
            ext_wdata.length = ext_q.length + fl_ff;
            state_in         = S_RESP;
         end else if (count_ff >= CNT_W'(MAX_FREE_EXTENTS)) begin
            res_st_in = ST_FULL;
            state_in  = S_RESP;
         end else begin
            // insert point kept in need_ff, walk from the end
            need_in  = NEED_W'(idx_ff);
            idx_in   = count_ff;
            state_in = S_INR;
         end
      end

      // pool re-creation
      if (csr_we) begin
         if (csr_wdata < LEN_W'(5))               pool_in = LEN_W'(5);
         else if (csr_wdata > LEN_W'(POOL_UNITS)) pool_in = LEN_W'(POOL_UNITS);
         else                                     pool_in = csr_wdata;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pool_ff      <= LEN_W'(POOL_UNITS);
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      act_ff      <= act_in;
      need_ff     <= need_in;
      addr_ff     <= addr_in;
      fs_ff       <= fs_in;
      fl_ff       <= fl_in;
      prev_ff     <= prev_in;
      has_prev_ff <= has_prev_in;
      res_st_ff   <= res_st_in;
      res_ua_ff   <= res_ua_in;
      res_gb_ff   <= res_gb_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_ua_ff   <= rsp_ua_in;
      rsp_gb_ff   <= rsp_gb_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_st_ff;
   assign rsp_chan.user_addr     = rsp_ua_ff;
   assign rsp_chan.granted_bytes = rsp_gb_ff;

   // checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FREE_EXTENTS))
      else $error("extent count overflow");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !csr_we) |=> (state_ff != S_IDLE))
      else $error("request accepted but block stayed idle");

   a_csr_init: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (state_ff == S_INIT))
      else $error("pool rebuild not started");

endmodule

FILE: tb/first_fit_coalescing_allocator_top_test.sv
`timescale 1ns / 100ps

module first_fit_coalescing_allocator_top_test;
   import ffca_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] user_addr;
      logic [15:0] granted;
   } resp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [LEN_W-1:0] csr_wdata = '0;

   ffca_req_if req_bus ();
   ffca_rsp_if rsp_bus ();

   first_fit_coalescing_allocator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow heap state
   int heap_start [MAX_FREE_EXTENTS];
   int heap_len   [MAX_FREE_EXTENTS];
   int heap_cnt;
   int pool_sz;
   int blk_units  [POOL_UNITS];
   bit blk_known  [POOL_UNITS];

   resp_type pending_rsp[$];
   int    live_addr[$];
   int    freed_addr[$];
   int    errors = 0;
   int    cycles = 0;
   bit    idle_on = 1'b1;
   int    hold_req = 0;
   bit    hold_on = 1'b0;

   // rebuild the pool as a csr_we pool size write does
   function automatic void rebuild_pool(int units);
      pool_sz = units < 5 ? 5 : (units > POOL_UNITS ? POOL_UNITS : units);
      for (int k = 0; k < POOL_UNITS; k++) begin
         blk_units[k] = 0;
         blk_known[k] = 1'b0;
      end
      heap_start[0] = 0;
      heap_len[0] = pool_sz;
      heap_cnt = 1;
   endfunction

   function automatic void drop_extent(int i);
      for (int k = i; k + 1 < heap_cnt; k++) begin
         heap_start[k] = heap_start[k+1];
         heap_len[k] = heap_len[k+1];
      end
      if (heap_cnt > 0) heap_cnt--;
   endfunction

   function automatic resp_type predict_alloc(logic [15:0] bytes);
      resp_type r;
      int need, i, start, units, sz;
      sz = bytes > MIN_BYTES_R8 ? int'(bytes) : MIN_BYTES_R8;
      need = (sz + HEADER_BYTES + 7) >> 3;
      i = 0;
      while (i < heap_cnt && heap_len[i] <= need) i++;
      if (i >= heap_cnt) begin
         r.status = ST_NO_SPACE;
         r.user_addr = '0;
         r.granted = '0;
         return r;
      end
      start = heap_start[i];
      // too small a remainder: grant the whole extent
      if (heap_len[i] < need + MIN_UNITS) begin
         units = heap_len[i];
         drop_extent(i);
      end else begin
         units = need;
         heap_start[i] = start + need;
         heap_len[i] -= need;
      end
      if (start < POOL_UNITS) begin
         blk_units[start] = units & 13'h1fff;
         blk_known[start] = 1'b1;
      end
      r.status = ST_OK;
      r.user_addr = 15'(start * 8 + HEADER_BYTES);
      r.granted = 16'(units * 8);
      return r;
   endfunction

   function automatic resp_type predict_free(logic [14:0] addr);
      resp_type r;
      int base, fs, fl, p;
      bit padj, nadj;
      r.user_addr = addr;
      r.granted = '0;
      r.status = ST_IGNORED;
      if (addr < HEADER_BYTES) return r;
      base = int'(addr) - HEADER_BYTES;
      fs = base >> 3;
      if ((base & 7) != 0 || fs >= pool_sz) return r;
      fl = blk_units[fs];
      if (fl > pool_sz - fs) fl = pool_sz - fs;
      r.granted = 16'(fl * 8);
      p = 0;
      while (p < heap_cnt && heap_start[p] <= fs) p++;
      padj = p > 0 && heap_start[p-1] + heap_len[p-1] == fs;
      nadj = p < heap_cnt && fs + fl == heap_start[p];
      if (padj) begin
         heap_len[p-1] += fl;
         if (nadj) begin
            heap_len[p-1] += heap_len[p];
            drop_extent(p);
         end
      end else if (nadj) begin
         heap_start[p] = fs;
         heap_len[p] += fl;
      end else begin
         if (heap_cnt >= MAX_FREE_EXTENTS) begin
            r.status = ST_FULL;
            return r;
         end
         for (int k = heap_cnt; k > p; k--) begin
            heap_start[k] = heap_start[k-1];
            heap_len[k] = heap_len[k-1];
         end
         heap_start[p] = fs;
         heap_len[p] = fl;
         heap_cnt++;
      end
      r.status = ST_OK;
      return r;
   endfunction

   // offer one request, predict at acceptance
   task automatic send_request(input logic act, input logic [15:0] bytes,
                               input logic [14:0] addr, output resp_type exp);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.req_bytes <= bytes;
      req_bus.block_addr <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      exp = (act == ACT_ALLOC) ? predict_alloc(bytes) : predict_free(addr);
      pending_rsp.push_back(exp);
   endtask

   task automatic do_alloc(input logic [15:0] bytes);
      resp_type exp;
      send_request(ACT_ALLOC, bytes, '0, exp);
      if (exp.status == ST_OK) live_addr.push_back(exp.user_addr);
   endtask

   task automatic do_free(input logic [14:0] addr);
      resp_type exp;
      send_request(ACT_FREE, '0, addr, exp);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // pool size write, only with the block idle
   task automatic write_pool(input logic [LEN_W-1:0] units);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= units;
      @(posedge clock);
      csr_we <= 1'b0;
      rebuild_pool(units);
      live_addr.delete();
      freed_addr.delete();
   endtask

   // free of a random offset; valid starts never written become misaligned
   function automatic logic [14:0] noise_addr();
      logic [14:0] a;
      int fs;
      a = 15'($urandom_range(0, 32767));
      fs = (int'(a) - HEADER_BYTES) >> 3;
      if (a >= HEADER_BYTES && ((int'(a) - HEADER_BYTES) & 7) == 0 && fs < pool_sz
          && !blk_known[fs])
         a = a | 15'd1;
      return a;
   endfunction

   task automatic test_basic_ops();
      logic [14:0] a;
      do_alloc(16'd0);
      do_alloc(16'd24);
      do_alloc(16'd25);
      do_alloc(16'd32768);
      do_alloc(16'hffff);
      do_free(15'd0);
      do_free(15'd4);
      do_free(15'd13);
      do_free(15'h7ff9);
      do_free(15'h7fff);
      // free the three blocks so that the last one merges on both sides
      a = live_addr[1];
      do_free(15'(live_addr[0]));
      do_free(15'(live_addr[2]));
      do_free(a);
      live_addr.delete();
      do_alloc(16'd32000);
      do_alloc(16'd4000);
      do_free(15'(live_addr[0]));
      live_addr.delete();
   endtask

   task automatic test_pool_extremes();
      write_pool(13'd0);
      do_alloc(16'd0);
      do_alloc(16'd0);
      do_free(15'(live_addr[0]));
      // start unit just past the pool end
      do_free(15'd48);
      write_pool(13'd5);
      do_alloc(16'd8);
      write_pool(13'h1fff);
      do_alloc(16'd32760);
      do_alloc(16'd0);
      write_pool(13'd4096);
   endtask

   // repeated free of one block keeps inserting entries until the table is full
   task automatic test_table_full();
      logic [14:0] a;
      write_pool(13'd4096);
      do_alloc(16'd0);
      do_alloc(16'd0);
      a = 15'(live_addr[0]);
      repeat (MAX_FREE_EXTENTS + 2) do_free(a);
      do_alloc(16'd0);
      write_pool(13'd4096);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_req = 3000;
      repeat (8) do_alloc(16'($urandom_range(0, 100)));
      idle_on = 1'b1;
      foreach (live_addr[i]) do_free(15'(live_addr[i]));
      live_addr.delete();
   endtask

   task automatic random_phase(input logic [LEN_W-1:0] units, input int count);
      int r, idx;
      logic [14:0] a;
      write_pool(units);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 42 && live_addr.size() != 0) begin
            idx = $urandom_range(0, live_addr.size() - 1);
            a = 15'(live_addr[idx]);
            live_addr.delete(idx);
            freed_addr.push_back(a);
            do_free(a);
         end else if (r < 45 && freed_addr.size() != 0) begin
            do_free(15'(freed_addr[$urandom_range(0, freed_addr.size() - 1)]));
         end else if (r < 53) begin
            do_free(noise_addr());
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60)      do_alloc(16'($urandom_range(0, 64)));
            else if (r < 85) do_alloc(16'($urandom_range(0, 600)));
            else if (r < 95) do_alloc(16'($urandom_range(0, 4096)));
            else if (r < 99) do_alloc(16'($urandom_range(4096, 32768)));
            else             do_alloc(16'($urandom_range(32768, 65535)));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random();
      random_phase(13'd4096, 200);
      random_phase(13'd64, 80);
      random_phase(13'($urandom_range(5, 4096)), 100);
      random_phase(13'd8191, 100);
      random_phase(13'($urandom_range(5, 300)), 70);
      random_phase(13'd3, 60);
   endtask

   // response side: random stall per response, plus any long hold
   initial begin : rsp_side
      int stall;
      resp_type exp;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 17);
         if (!idle_on) stall = 0;
         if (stall > 0 || hold_on) begin
            rsp_bus.ready <= 1'b0;
            while (stall > 0 || hold_on) begin
               @(posedge clock);
               if (stall > 0) stall--;
            end
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: status %0d addr %0d bytes %0d",
                     $time, rsp_bus.status, rsp_bus.user_addr, rsp_bus.granted_bytes);
         end else begin
            exp = pending_rsp.pop_front();
            if (rsp_bus.status !== exp.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, exp.status,
                        rsp_bus.status);
            end
            if (rsp_bus.user_addr !== exp.user_addr) begin
               errors++;
               $display("%0t: user_addr expected %0d actual %0d", $time, exp.user_addr,
                        rsp_bus.user_addr);
            end
            if (rsp_bus.granted_bytes !== exp.granted) begin
               errors++;
               $display("%0t: granted_bytes expected %0d actual %0d", $time, exp.granted,
                        rsp_bus.granted_bytes);
            end
         end
      end
   end

   // long receiver hold, counted here
   initial begin : hold_counter
      int n;
      forever begin
         wait (hold_req > 0);
         n = hold_req;
         hold_req = 0;
         hold_on = 1'b1;
         repeat (n) @(posedge clock);
         hold_on = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.action = ACT_ALLOC;
      req_bus.req_bytes = '0;
      req_bus.block_addr = '0;
      rebuild_pool(POOL_UNITS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_pool_extremes();
      test_backpressure();
      test_table_full();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
